@@ rtl/pol_pkg.sv @@
// Package for the polyline point-at-arc-length block.
// Holds the widths, the action codes, the state enums and the unit request and response structs.
// Depends on nothing.
`default_nettype none

package pol_pkg;

  localparam int unsigned MaxEdges = 256;
  localparam int unsigned IdxW     = $clog2(MaxEdges);
  localparam int unsigned CntW     = IdxW + 1;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned LenW     = 48;
  localparam int unsigned PtsW     = 4 * CoordW;
  localparam int unsigned RootW    = CoordW + 1;
  localparam int unsigned StepW    = 6;

  localparam logic [LenW-1:0] LenMax = {1'b0, {(LenW-1){1'b1}}};

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_NONE   = 2'd3
  } act_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LEN,
    ST_QCHK,
    ST_MOD,
    ST_SRCH,
    ST_SCMP,
    ST_CI_RD,
    ST_CI_USE,
    ST_BASE_USE,
    ST_EVAL,
    ST_TDIV,
    ST_PT_RD,
    ST_PT_USE,
    ST_MULX,
    ST_ADDX,
    ST_MULY,
    ST_ADDY,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SEL_START,
    SEL_END,
    SEL_LERP
  } sel_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_X,
    SQ_Y,
    SQ_ROOT
  } sq_phase_e;

  typedef struct packed {
    logic              start;
    logic [RootW-1:0]  ax;
    logic [RootW-1:0]  ay;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [RootW-1:0]  root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic              start;
    logic [StepW-1:0]  steps;
    logic [LenW-1:0]   init_rem;
    logic [LenW-1:0]   num;
    logic [LenW-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [LenW-1:0]   rem;
    logic [LenW-1:0]   quo;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/pol_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module pol_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/pol_sqrt.sv @@
// Edge length unit: squares both axis magnitudes by shift and add, then takes
// the floor square root two radicand bits per cycle. Depends on pol_pkg.
`default_nettype none

module pol_sqrt (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pol_pkg::sqrt_req_t req_i,
  output pol_pkg::sqrt_rsp_t      rsp_o
);

  localparam int unsigned RW = pol_pkg::RootW;
  localparam int unsigned AW = 2 * RW;
  localparam int unsigned MW = RW + 3;

  pol_pkg::sq_phase_e phase_q, phase_d;
  logic [pol_pkg::StepW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] mcand_q, mcand_d, acc_q, acc_d, rad_q, rad_d;
  logic [RW-1:0] mplier_q, mplier_d, ay_q, ay_d, root_q, root_d;
  logic [MW-1:0] rem_q, rem_d;
  logic done_q, done_d;
  logic [AW-1:0] acc_sum;
  logic [MW-1:0] rem2, trial;

  always_comb begin
    acc_sum  = acc_q + (mplier_q[0] ? mcand_q : '0);
    rem2     = {rem_q[MW-3:0], rad_q[AW-1:AW-2]};
    trial    = {1'b0, root_q, 2'b01};
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    acc_d    = acc_q;
    rad_d    = rad_q;
    mplier_d = mplier_q;
    ay_d     = ay_q;
    root_d   = root_q;
    rem_d    = rem_q;
    done_d   = 1'b0;
    case (phase_q)
      pol_pkg::SQ_IDLE: begin
        if (req_i.start) begin
          mcand_d  = {{RW{1'b0}}, req_i.ax};
          mplier_d = req_i.ax;
          ay_d     = req_i.ay;
          acc_d    = '0;
          cnt_d    = pol_pkg::StepW'(RW - 1);
          phase_d  = pol_pkg::SQ_X;
        end
      end
      pol_pkg::SQ_X, pol_pkg::SQ_Y: begin
        acc_d    = acc_sum;
        mcand_d  = {mcand_q[AW-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[RW-1:1]};
        cnt_d    = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d = pol_pkg::StepW'(RW - 1);
          if (phase_q == pol_pkg::SQ_X) begin
            mcand_d  = {{RW{1'b0}}, ay_q};
            mplier_d = ay_q;
            phase_d  = pol_pkg::SQ_Y;
          end else begin
            rad_d   = acc_sum;
            rem_d   = '0;
            root_d  = '0;
            phase_d = pol_pkg::SQ_ROOT;
          end
        end
      end
      pol_pkg::SQ_ROOT: begin
        if (rem2 >= trial) begin
          rem_d  = rem2 - trial;
          root_d = {root_q[RW-2:0], 1'b1};
        end else begin
          rem_d  = rem2;
          root_d = {root_q[RW-2:0], 1'b0};
        end
        rad_d = {rad_q[AW-3:0], 2'b00};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = pol_pkg::SQ_IDLE;
        end
      end
      default: phase_d = pol_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pol_pkg::SQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    mcand_q  <= mcand_d;
    acc_q    <= acc_d;
    rad_q    <= rad_d;
    mplier_q <= mplier_d;
    ay_q     <= ay_d;
    root_q   <= root_d;
    rem_q    <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.root = root_q;

endmodule

`default_nettype wire

@@ rtl/pol_div.sv @@
// Restoring divider, one quotient bit per cycle, for the wrap modulo and the
// edge fraction. Depends on pol_pkg.
`default_nettype none

module pol_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pol_pkg::div_req_t req_i,
  output pol_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned W = pol_pkg::LenW;

  logic busy_q, busy_d, done_q, done_d;
  logic [pol_pkg::StepW-1:0] cnt_q, cnt_d;
  logic [W-1:0] r_q, r_d, num_q, num_d, quo_q, quo_d, dv_q, dv_d;
  logic [W:0] r2;

  always_comb begin
    r2     = {r_q, num_q[W-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    num_d  = num_q;
    quo_d  = quo_q;
    dv_d   = dv_q;
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        cnt_d  = req_i.steps - 1'b1;
        r_d    = req_i.init_rem;
        num_d  = req_i.num;
        quo_d  = '0;
        dv_d   = req_i.divisor;
      end
    end else begin
      num_d = {num_q[W-2:0], 1'b0};
      if (r2 >= {1'b0, dv_q}) begin
        r_d   = W'(r2 - {1'b0, dv_q});
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        r_d   = r2[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    r_q   <= r_d;
    num_q <= num_d;
    quo_q <= quo_d;
    dv_q  <= dv_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

@@ rtl/polyline_point_at_arc_length.sv @@
// Polyline point at arc length: top level with the sequencer, the length and point RAMs,
// the length unit and the divider. Depends on pol_pkg, pol_ram, pol_sqrt, pol_div.
// One item at a time. A clear only zeroes the count and total; an append that finds room
// in the table runs the squaring and square root loops of pol_sqrt; a query may run the
// wrap modulo (48-bit divide), the binary search (ST_SRCH, ST_SCMP per step) and the
// 32-bit fraction. Reset empties the path at once; the RAM contents are never cleared.
`default_nettype none

module polyline_point_at_arc_length (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata: start_x, start_y, end_x, end_y, arc_length, clamp_ends, zero pad.
  input  wire logic [183:0] s_axis_tdata,
  // tuser: action.
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // tdata: point_x, point_y.
  output logic [63:0]       m_axis_tdata,
  // tuser: status.
  output logic [0:0]        m_axis_tuser
);

  localparam int unsigned CW = pol_pkg::CoordW;
  localparam int unsigned LW = pol_pkg::LenW;
  localparam int unsigned IW = pol_pkg::IdxW;

  pol_pkg::state_e state_q, state_d;
  pol_pkg::sel_e sel_q, sel_d;
  logic [pol_pkg::CntW-1:0] count_q, count_d;
  logic [LW-1:0] total_q, total_d, cur_q, cur_d, base_q, base_d;
  logic signed [LW-1:0] l_q, l_d;
  logic clamp_q, clamp_d, wneg_q, wneg_d, neg_q, neg_d;
  logic [pol_pkg::PtsW-1:0] in_pts_q, in_pts_d, pts_q, pts_d;
  logic [IW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d, mid;
  logic [31:0] t_q, t_d;
  logic [2*CW:0] prod_q, prod_d;
  logic [CW-1:0] resx_q, resx_d, resy_q, resy_d, mx_q, mx_d, my_q, my_d;
  logic res_st_q, res_st_d, mst_q, mst_d, mvalid_q, mvalid_d;

  logic in_xfer;
  pol_pkg::act_e act;
  logic signed [CW:0] dsx, dsy, dlx, dly;
  logic [CW:0] mag_l;
  logic signed [LW:0] l49, tot49, ledge;
  logic [LW-1:0] len, l_abs;
  logic [LW:0] cum_sum;
  logic [IW:0] mid_sum;
  logic [CW:0] off;

  logic cum_we, pts_we;
  logic [IW-1:0] cum_raddr;
  logic [LW-1:0] cum_rdata;
  logic [pol_pkg::PtsW-1:0] pts_rdata;

  pol_pkg::sqrt_req_t sq_req;
  pol_pkg::sqrt_rsp_t sq_rsp;
  pol_pkg::div_req_t  dv_req;
  pol_pkg::div_rsp_t  dv_rsp;

  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign act     = pol_pkg::act_e'(s_axis_tuser);
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[IW:1];
  assign l49     = {l_q[LW-1], l_q};
  assign tot49   = {1'b0, total_q};
  assign l_abs   = LW'(-l_q);
  assign len     = cur_q - base_q;
  assign ledge   = l49 - $signed({1'b0, base_q});
  assign cum_sum = {1'b0, total_q} + {{(LW-CW){1'b0}}, sq_rsp.root};
  assign off     = prod_q[2*CW:CW];

  assign dsx = $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
             - $signed({s_axis_tdata[31], s_axis_tdata[31:0]});
  assign dsy = $signed({s_axis_tdata[127], s_axis_tdata[127:96]})
             - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
  assign dlx = $signed({pts_q[95], pts_q[95:64]}) - $signed({pts_q[31], pts_q[31:0]});
  assign dly = $signed({pts_q[127], pts_q[127:96]}) - $signed({pts_q[63], pts_q[63:32]});
  assign mag_l = (state_q == pol_pkg::ST_MULX) ? (dlx[CW] ? CW'(0) - dlx : dlx)
                                               : (dly[CW] ? CW'(0) - dly : dly);

  assign sq_req.start = in_xfer && (act == pol_pkg::ACT_APPEND)
                        && (count_q < pol_pkg::CntW'(pol_pkg::MaxEdges));
  assign sq_req.ax    = dsx[CW] ? (CW+1)'(-dsx) : dsx;
  assign sq_req.ay    = dsy[CW] ? (CW+1)'(-dsy) : dsy;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pol_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (act)
            pol_pkg::ACT_APPEND: if (sq_req.start) state_d = pol_pkg::ST_LEN;
            pol_pkg::ACT_QUERY:
              state_d = (count_q == '0) ? pol_pkg::ST_OUT : pol_pkg::ST_QCHK;
            default: state_d = pol_pkg::ST_IDLE;
          endcase
        end
      end
      pol_pkg::ST_LEN: if (sq_rsp.done) state_d = pol_pkg::ST_IDLE;
      pol_pkg::ST_QCHK: begin
        if (l49 == tot49 || l_q == '0) begin
          state_d = pol_pkg::ST_PT_RD;
        end else if ((l49 > tot49 || l_q < 0) && clamp_q) begin
          state_d = pol_pkg::ST_PT_RD;
        end else if ((l49 > tot49 || l_q < 0) && total_q != '0) begin
          state_d = pol_pkg::ST_MOD;
        end else begin
          state_d = pol_pkg::ST_SRCH;
        end
      end
      pol_pkg::ST_MOD: if (dv_rsp.done) state_d = pol_pkg::ST_SRCH;
      pol_pkg::ST_SRCH: state_d = (lo_q < hi_q) ? pol_pkg::ST_SCMP : pol_pkg::ST_CI_RD;
      pol_pkg::ST_SCMP: state_d = pol_pkg::ST_SRCH;
      pol_pkg::ST_CI_RD: state_d = pol_pkg::ST_CI_USE;
      pol_pkg::ST_CI_USE:
        state_d = (idx_q == '0) ? pol_pkg::ST_EVAL : pol_pkg::ST_BASE_USE;
      pol_pkg::ST_BASE_USE: state_d = pol_pkg::ST_EVAL;
      pol_pkg::ST_EVAL: begin
        if (len == '0 || ledge[LW] || $unsigned(ledge[LW-1:0]) >= len) begin
          state_d = pol_pkg::ST_PT_RD;
        end else begin
          state_d = pol_pkg::ST_TDIV;
        end
      end
      pol_pkg::ST_TDIV: if (dv_rsp.done) state_d = pol_pkg::ST_PT_RD;
      pol_pkg::ST_PT_RD: state_d = pol_pkg::ST_PT_USE;
      pol_pkg::ST_PT_USE:
        state_d = (sel_q == pol_pkg::SEL_LERP) ? pol_pkg::ST_MULX : pol_pkg::ST_OUT;
      pol_pkg::ST_MULX: state_d = pol_pkg::ST_ADDX;
      pol_pkg::ST_ADDX: state_d = pol_pkg::ST_MULY;
      pol_pkg::ST_MULY: state_d = pol_pkg::ST_ADDY;
      pol_pkg::ST_ADDY: state_d = pol_pkg::ST_OUT;
      pol_pkg::ST_OUT: if (!mvalid_q || m_axis_tready) state_d = pol_pkg::ST_IDLE;
      default: state_d = pol_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    sel_d    = sel_q;
    count_d  = count_q;
    total_d  = total_q;
    cur_d    = cur_q;
    base_d   = base_q;
    l_d      = l_q;
    clamp_d  = clamp_q;
    wneg_d   = wneg_q;
    neg_d    = neg_q;
    in_pts_d = in_pts_q;
    pts_d    = pts_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    idx_d    = idx_q;
    t_d      = t_q;
    prod_d   = prod_q;
    resx_d   = resx_q;
    resy_d   = resy_q;
    res_st_d = res_st_q;
    mx_d     = mx_q;
    my_d     = my_q;
    mst_d    = mst_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    cum_we   = 1'b0;
    pts_we   = 1'b0;
    dv_req   = '0;
    cum_raddr = idx_q;
    case (state_q)
      pol_pkg::ST_IDLE: begin
        if (in_xfer) begin
          in_pts_d = s_axis_tdata[127:0];
          l_d      = s_axis_tdata[175:128];
          clamp_d  = s_axis_tdata[176];
          resx_d   = '0;
          resy_d   = '0;
          res_st_d = 1'b1;
          lo_d     = '0;
          hi_d     = IW'(count_q - 1'b1);
          if (act == pol_pkg::ACT_CLEAR) begin
            count_d = '0;
            total_d = '0;
          end
        end
      end
      pol_pkg::ST_LEN: begin
        if (sq_rsp.done) begin
          cum_we  = 1'b1;
          pts_we  = 1'b1;
          total_d = (cum_sum > {1'b0, pol_pkg::LenMax}) ? pol_pkg::LenMax : cum_sum[LW-1:0];
          count_d = count_q + 1'b1;
        end
      end
      pol_pkg::ST_QCHK: begin
        res_st_d = 1'b0;
        wneg_d   = l_q < 0;
        if (l49 == tot49) begin
          idx_d = hi_q;
          sel_d = pol_pkg::SEL_END;
        end else if (l_q == '0) begin
          idx_d = '0;
          sel_d = pol_pkg::SEL_START;
        end else if ((l49 > tot49 || l_q < 0) && clamp_q) begin
          idx_d = (l_q < 0) ? '0 : hi_q;
          sel_d = (l_q < 0) ? pol_pkg::SEL_START : pol_pkg::SEL_END;
        end else if ((l49 > tot49 || l_q < 0) && total_q != '0) begin
          dv_req.start   = 1'b1;
          dv_req.steps   = pol_pkg::StepW'(LW);
          dv_req.num     = (l_q < 0) ? l_abs : l_q;
          dv_req.divisor = total_q;
        end else if (l49 > tot49 || l_q < 0) begin
          l_d = '0;
        end
      end
      pol_pkg::ST_MOD: begin
        if (dv_rsp.done) begin
          l_d = wneg_q ? $signed(total_q - dv_rsp.rem) : $signed(dv_rsp.rem);
        end
      end
      pol_pkg::ST_SRCH: begin
        cum_raddr = mid;
        idx_d     = lo_q;
      end
      pol_pkg::ST_SCMP: begin
        if (l49 <= $signed({1'b0, cum_rdata})) begin
          hi_d = mid;
        end else begin
          lo_d = mid + 1'b1;
        end
      end
      pol_pkg::ST_CI_USE: begin
        cur_d     = cum_rdata;
        base_d    = '0;
        cum_raddr = idx_q - 1'b1;
      end
      pol_pkg::ST_BASE_USE: base_d = cum_rdata;
      pol_pkg::ST_EVAL: begin
        if (len == '0) begin
          sel_d = pol_pkg::SEL_START;
        end else if (!ledge[LW] && $unsigned(ledge[LW-1:0]) >= len) begin
          sel_d = pol_pkg::SEL_END;
        end else if (ledge[LW]) begin
          sel_d = pol_pkg::SEL_START;
        end else begin
          dv_req.start    = 1'b1;
          dv_req.steps    = pol_pkg::StepW'(32);
          dv_req.init_rem = ledge[LW-1:0];
          dv_req.divisor  = len;
        end
      end
      pol_pkg::ST_TDIV: begin
        if (dv_rsp.done) begin
          t_d   = dv_rsp.quo[31:0];
          sel_d = pol_pkg::SEL_LERP;
        end
      end
      pol_pkg::ST_PT_USE: begin
        pts_d = pts_rdata;
        if (sel_q == pol_pkg::SEL_END) begin
          resx_d = pts_rdata[95:64];
          resy_d = pts_rdata[127:96];
        end else begin
          resx_d = pts_rdata[31:0];
          resy_d = pts_rdata[63:32];
        end
      end
      pol_pkg::ST_MULX: begin
        prod_d = (2*CW+1)'(mag_l) * (2*CW+1)'(t_q);
        neg_d  = dlx[CW];
      end
      pol_pkg::ST_ADDX: resx_d = neg_q ? pts_q[31:0] - off[CW-1:0] : pts_q[31:0] + off[CW-1:0];
      pol_pkg::ST_MULY: begin
        prod_d = (2*CW+1)'(mag_l) * (2*CW+1)'(t_q);
        neg_d  = dly[CW];
      end
      pol_pkg::ST_ADDY: resy_d = neg_q ? pts_q[63:32] - off[CW-1:0] : pts_q[63:32] + off[CW-1:0];
      pol_pkg::ST_OUT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mx_d     = resx_q;
          my_d     = resy_q;
          mst_d    = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pol_pkg::ST_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q    <= sel_d;
    cur_q    <= cur_d;
    base_q   <= base_d;
    l_q      <= l_d;
    clamp_q  <= clamp_d;
    wneg_q   <= wneg_d;
    neg_q    <= neg_d;
    in_pts_q <= in_pts_d;
    pts_q    <= pts_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    idx_q    <= idx_d;
    t_q      <= t_d;
    prod_q   <= prod_d;
    resx_q   <= resx_d;
    resy_q   <= resy_d;
    res_st_q <= res_st_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    mst_q    <= mst_d;
  end

  pol_ram #(.Width(LW), .Depth(pol_pkg::MaxEdges)) u_cum_ram (
    .clk_i   (clk_i),
    .we_i    (cum_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (total_d),
    .raddr_i (cum_raddr),
    .rdata_o (cum_rdata)
  );

  pol_ram #(.Width(pol_pkg::PtsW), .Depth(pol_pkg::MaxEdges)) u_pts_ram (
    .clk_i   (clk_i),
    .we_i    (pts_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (in_pts_q),
    .raddr_i (idx_q),
    .rdata_o (pts_rdata)
  );

  pol_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .rsp_o  (sq_rsp)
  );

  pol_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dv_req),
    .rsp_o  (dv_rsp)
  );

  assign s_axis_tready   = (state_q == pol_pkg::ST_IDLE);
  assign m_axis_tvalid   = mvalid_q;
  assign m_axis_tdata    = {my_q, mx_q};
  assign m_axis_tuser[0] = mst_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= pol_pkg::CntW'(pol_pkg::MaxEdges))
    else $error("edge count beyond table size");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= pol_pkg::LenMax)
    else $error("total length beyond saturation limit");

  a_append_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_req.start |=> (state_q == pol_pkg::ST_LEN))
    else $error("append transfer did not start the length unit");

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the polyline point-at-arc-length block.
// Streams clear, append, query and no-op transfers into the block, predicts each
// point from its own copy of the path and checks every result. Uses pol_pkg.
`default_nettype none

module tb_top;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic        st;
  } point_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [183:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  polyline_point_at_arc_length dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  longint path_sx [pol_pkg::MaxEdges];
  longint path_sy [pol_pkg::MaxEdges];
  longint path_ex [pol_pkg::MaxEdges];
  longint path_ey [pol_pkg::MaxEdges];
  longint cum_len [pol_pkg::MaxEdges];
  int unsigned n_edges;
  longint total_len;

  point_t pending_points[$];
  int unsigned errors;
  int unsigned items_sent;
  int unsigned points_checked;
  int unsigned hold_cycles;
  int unsigned no_gap_left;

  always #10 clk_i = ~clk_i;

  function automatic longint unsigned edge_root(longint dx, longint dy);
    logic [127:0] ax;
    logic [127:0] ay;
    logic [127:0] sum;
    logic [127:0] r;
    logic [127:0] c;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sum = ax * ax + ay * ay;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= sum) r = c;
    end
    return r[63:0];
  endfunction

  function automatic logic [31:0] lerp(longint a, longint b, longint unsigned t);
    longint d;
    logic [127:0] prod;
    longint off;
    d = b - a;
    prod = 128'((d < 0) ? -d : d) * 128'(t);
    off = longint'(prod >> 32);
    return (d < 0) ? 32'(a - off) : 32'(a + off);
  endfunction

  function automatic void push_point(longint x, longint y, logic st);
    point_t p;
    p.px = 32'(x);
    p.py = 32'(y);
    p.st = st;
    pending_points = {pending_points, p};
  endfunction

  // Updates the path copy for one accepted transfer and, for a query, queues the point it yields.
  function automatic void track_path(pol_pkg::act_e act, logic [183:0] data);
    longint sx, sy, ex, ey, len, l, base, ledge;
    longint unsigned rem, t;
    int unsigned lo, hi, mid, i;
    logic clamp;
    sx = longint'($signed(data[31:0]));
    sy = longint'($signed(data[63:32]));
    ex = longint'($signed(data[95:64]));
    ey = longint'($signed(data[127:96]));
    l = longint'($signed(data[175:128]));
    clamp = data[176];
    case (act)
      pol_pkg::ACT_CLEAR: begin
        n_edges = 0;
        total_len = 0;
      end
      pol_pkg::ACT_APPEND: begin
        if (n_edges < pol_pkg::MaxEdges) begin
          path_sx[n_edges] = sx;
          path_sy[n_edges] = sy;
          path_ex[n_edges] = ex;
          path_ey[n_edges] = ey;
          len = longint'(edge_root(ex - sx, ey - sy));
          base = (n_edges == 0) ? 0 : cum_len[n_edges - 1];
          cum_len[n_edges] = (len > longint'(pol_pkg::LenMax) - base) ?
                             longint'(pol_pkg::LenMax) : base + len;
          total_len = cum_len[n_edges];
          n_edges++;
        end
      end
      pol_pkg::ACT_QUERY: begin
        if (n_edges == 0) begin
          push_point(0, 0, 1'b1);
          return;
        end
        if (l == total_len) begin
          push_point(path_ex[n_edges - 1], path_ey[n_edges - 1], 1'b0);
          return;
        end
        if (l == 0) begin
          push_point(path_sx[0], path_sy[0], 1'b0);
          return;
        end
        if (l > total_len) begin
          if (clamp) begin
            push_point(path_ex[n_edges - 1], path_ey[n_edges - 1], 1'b0);
            return;
          end
          l = (total_len > 0) ? l % total_len : 0;
        end else if (l < 0) begin
          if (clamp) begin
            push_point(path_sx[0], path_sy[0], 1'b0);
            return;
          end
          l = (total_len > 0) ? total_len - ((-l) % total_len) : 0;
        end
        lo = 0;
        hi = n_edges - 1;
        while (lo < hi) begin
          mid = (lo + hi) / 2;
          if (l <= cum_len[mid]) hi = mid;
          else lo = mid + 1;
        end
        i = lo;
        base = (i == 0) ? 0 : cum_len[i - 1];
        len = cum_len[i] - base;
        ledge = (l - base < 0) ? 0 : l - base;
        if (len <= 0) begin
          push_point(path_sx[i], path_sy[i], 1'b0);
        end else if (ledge >= len) begin
          push_point(path_ex[i], path_ey[i], 1'b0);
        end else begin
          rem = ledge;
          t = 0;
          for (int k = 0; k < 32; k++) begin
            rem = rem << 1;
            t = t << 1;
            if (rem >= longint'(len)) begin
              rem -= len;
              t |= 1;
            end
          end
          push_point(lerp(path_sx[i], path_ex[i], t), lerp(path_sy[i], path_ey[i], t), 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_item(pol_pkg::act_e act, logic [31:0] sx, logic [31:0] sy,
                           logic [31:0] ex, logic [31:0] ey, logic [47:0] arc,
                           logic clamp);
    int unsigned gap;
    logic [183:0] data;
    data = {7'd0, clamp, arc, ey, ex, sy, sx};
    if (no_gap_left > 0) begin
      gap = 0;
      no_gap_left--;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 29) == 0) no_gap_left = 20;
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    track_path(act, data);
    items_sent++;
  endtask

  task automatic send_append(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey);
    send_item(pol_pkg::ACT_APPEND, sx, sy, ex, ey, 48'($urandom), 1'($urandom));
  endtask

  task automatic send_query(logic [47:0] arc, logic clamp);
    send_item(pol_pkg::ACT_QUERY, $urandom, $urandom, $urandom, $urandom, arc, clamp);
  endtask

  function automatic logic [47:0] pick_length();
    longint unsigned r;
    longint span;
    r = {$urandom, $urandom};
    span = total_len + 1;
    case ($urandom_range(0, 9))
      0: return 48'(total_len);
      1: return 48'd0;
      2: return 48'(total_len + $urandom_range(1, 1000));
      3: return 48'(-longint'(r % span) - 1);
      4: return 48'(r);
      5: return 48'(-total_len - longint'(r % span));
      6: return 48'(cum_len[$urandom_range(0, (n_edges > 0) ? n_edges - 1 : 0)]);
      default: return 48'(r % span);
    endcase
  endfunction

  task automatic test_empty_path();
    send_query(48'd0, 1'b1);
    send_query(48'h7FFF_FFFF_FFFF, 1'b0);
    send_item(pol_pkg::ACT_NONE, '1, '1, '1, '1, '1, 1'b1);
    send_item(pol_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    send_query(48'h8000_0000_0000, 1'b0);
  endtask

  task automatic test_directed_cases();
    send_append(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_append(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_append(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0002_0000);
    send_query(48'd0, 1'b0);
    send_query(48'(total_len), 1'b1);
    send_query(48'(total_len + 5), 1'b1);
    send_query(48'(total_len + 5), 1'b0);
    send_query(48'(-7), 1'b1);
    send_query(48'(-7), 1'b0);
    send_query(48'(cum_len[0]), 1'b0);
    send_query(48'(cum_len[0] / 3), 1'b0);
    send_query(48'h7FFF_FFFF_FFFF, 1'b0);
    send_query(48'h8000_0000_0000, 1'b0);
    send_item(pol_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    send_append(32'h0003_0000, 32'hFFFD_0000, 32'h0003_0000, 32'hFFFD_0000);
    send_query(48'd5, 1'b0);
    send_query(48'(-5), 1'b0);
    send_query(48'd5, 1'b1);
  endtask

  task automatic test_full_table();
    logic [31:0] x, y;
    send_item(pol_pkg::ACT_CLEAR, '0, '0, '0, '0, '0, 1'b0);
    x = $urandom;
    y = $urandom;
    for (int k = 0; k < pol_pkg::MaxEdges + 4; k++) begin
      send_append(x, y, x + $urandom_range(0, 1 << 20), y - $urandom_range(0, 1 << 20));
      x = $urandom;
      y = $urandom;
    end
    repeat (20) send_query(pick_length(), 1'($urandom));
  endtask

  task automatic test_random_paths(int unsigned target);
    logic [31:0] x, y, nx, ny;
    int unsigned edges, queries;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) != 0) send_item(pol_pkg::ACT_CLEAR, $urandom, $urandom,
                                               $urandom, $urandom, 48'($urandom),
                                               1'($urandom));
      edges = $urandom_range(1, 8);
      x = $urandom;
      y = $urandom;
      for (int k = 0; k < edges; k++) begin
        case ($urandom_range(0, 5))
          0: begin nx = $urandom; ny = $urandom; end
          1: begin nx = x; ny = y; end
          default: begin
            nx = x + $urandom_range(0, 1 << 22) - (1 << 21);
            ny = y + $urandom_range(0, 1 << 22) - (1 << 21);
          end
        endcase
        send_append(x, y, nx, ny);
        x = ($urandom_range(0, 7) == 0) ? $urandom : nx;
        y = ($urandom_range(0, 7) == 0) ? $urandom : ny;
      end
      queries = $urandom_range(2, 12);
      for (int k = 0; k < queries; k++) begin
        if ($urandom_range(0, 19) == 0) send_item(pol_pkg::ACT_NONE, $urandom, $urandom,
                                                  $urandom, $urandom, 48'($urandom),
                                                  1'($urandom));
        else send_query(pick_length(), 1'($urandom));
      end
    end
  endtask

  task automatic test_output_stall();
    hold_cycles = 400;
    repeat (12) send_query(pick_length(), 1'($urandom));
    s_axis_tvalid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (6) send_query(pick_length(), 1'($urandom));
  endtask

  initial begin
    int unsigned stall;
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      stall = (no_gap_left > 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid && hold_cycles == 0);
    end
  end

  always @(posedge clk_i) begin
    point_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h status=%b", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        errors++;
      end else begin
        want = pending_points.pop_front();
        points_checked++;
        if (m_axis_tdata[31:0] !== want.px) begin
          $display("%0t: point_x expected %h actual %h", $time, want.px, m_axis_tdata[31:0]);
          errors++;
        end
        if (m_axis_tdata[63:32] !== want.py) begin
          $display("%0t: point_y expected %h actual %h", $time, want.py, m_axis_tdata[63:32]);
          errors++;
        end
        if (m_axis_tuser[0] !== want.st) begin
          $display("%0t: status expected %b actual %b", $time, want.st, m_axis_tuser[0]);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("polyline_point_at_arc_length test failed");
    $finish;
  end

  initial begin
    clk_i = 1'b0;
    rst_ni <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= pol_pkg::ACT_NONE;
    m_axis_tready <= 1'b0;
    n_edges = 0;
    total_len = 0;
    errors = 0;
    items_sent = 0;
    points_checked = 0;
    hold_cycles = 0;
    no_gap_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_path();
    test_directed_cases();
    test_full_table();
    test_random_paths(800);
    test_output_stall();
    test_random_paths(1150);
    s_axis_tvalid <= 1'b0;
    wait (pending_points.size() == 0);
    repeat (150) @(posedge clk_i);
    $display("Sent %0d transfers and checked %0d points, covering empty, wrapped, clamped,",
             items_sent, points_checked);
    $display("zero-length and full-table paths under random stalls on both sides.");
    if (errors == 0 && pending_points.size() == 0) begin
      $display("polyline_point_at_arc_length test passed");
    end else begin
      $display("polyline_point_at_arc_length test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ polyline_point_at_arc_length.f @@
rtl/pol_pkg.sv
rtl/pol_ram.sv
rtl/pol_sqrt.sv
rtl/pol_div.sv
rtl/polyline_point_at_arc_length.sv
tb/sv/tb_top.sv
